FILE: rtl/dagp_pkg.sv
// ----------------------------------------------------------------------------
// dagp_pkg
// Types, constants, microcode program and helpers for the dual-axis gimbal PID.
// ----------------------------------------------------------------------------
package dagp_pkg;

	// request actions
	typedef enum logic [1:0] {
		ACT_RATE       = 2'd0,
		ACT_PITCH_TURN = 2'd1,
		ACT_YAW_TURN   = 2'd2,
		ACT_NULL       = 2'd3
	} action_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_RATE_KP  = 3'd0,
		REG_RATE_KI  = 3'd1,
		REG_RATE_KD  = 3'd2,
		REG_TURN_KP  = 3'd3,
		REG_TURN_KI  = 3'd4,
		REG_TURN_KD  = 3'd5,
		REG_TIME     = 3'd6,
		REG_INV_TIME = 3'd7
	} reg_index_t;

	// register reset values
	localparam logic signed [31:0] RST_RATE_KP  = 32'sd99824435;
	localparam logic signed [31:0] RST_RATE_KI  = 32'sd499122176;
	localparam logic signed [31:0] RST_RATE_KD  = 32'sd9982444;
	localparam logic signed [31:0] RST_TURN_KP  = 32'sd33554;
	localparam logic signed [31:0] RST_TURN_KI  = 32'sd16777;
	localparam logic signed [31:0] RST_TURN_KD  = 32'sd33554;
	localparam logic [30:0]        RST_TIME     = 31'd655;
	localparam logic [30:0]        RST_INV_TIME = 31'd6553600;

	// multiplier operand A source
	typedef enum logic [2:0] {
		A_NONE,
		A_DIFF,
		A_ERR,
		A_DERIV,
		A_INT_HI,
		A_INT_LO
	} a_sel_t;

	// multiplier operand B source
	typedef enum logic [2:0] {
		B_NONE,
		B_INV_TIME,
		B_TIME,
		B_KP,
		B_KD,
		B_KI
	} b_sel_t;

	// what a step does with the registered product
	typedef enum logic [3:0] {
		OP_NONE,
		OP_DERIV,
		OP_INTEG,
		OP_ACC_LOAD,
		OP_ACC_ADD,
		OP_HOLD_HI,
		OP_TERM,
		OP_FINISH,
		OP_ZERO
	} op_t;

	// sequencing of a step
	typedef enum logic [1:0] {
		SQ_NEXT,
		SQ_WAIT_IN,
		SQ_WAIT_OUT
	} seq_t;

	typedef logic [3:0] step_t;

	typedef struct packed {
		a_sel_t a_sel;
		b_sel_t b_sel;
		op_t    op;
		seq_t   seq;
		step_t  target;
	} ctl_word_t;

	// step addresses
	localparam step_t STEP_IDLE   = 4'd0;
	localparam step_t STEP_DIFF   = 4'd1;
	localparam step_t STEP_INC    = 4'd2;
	localparam step_t STEP_KP     = 4'd3;
	localparam step_t STEP_KD     = 4'd4;
	localparam step_t STEP_KI_HI  = 4'd5;
	localparam step_t STEP_KI_LO  = 4'd6;
	localparam step_t STEP_TERM   = 4'd7;
	localparam step_t STEP_FINISH = 4'd8;
	localparam step_t STEP_ZERO   = 4'd9;

	// control store
	function automatic ctl_word_t ucode_rom(input step_t s);
		ctl_word_t w;
		w = '{a_sel: A_NONE, b_sel: B_NONE, op: OP_NONE, seq: SQ_WAIT_IN, target: STEP_ZERO};
		unique case (s)
			STEP_IDLE: begin
				w = '{a_sel: A_NONE, b_sel: B_NONE, op: OP_NONE, seq: SQ_WAIT_IN,
					target: STEP_ZERO};
			end
			STEP_DIFF: begin
				w = '{a_sel: A_DIFF, b_sel: B_INV_TIME, op: OP_NONE, seq: SQ_NEXT,
					target: STEP_IDLE};
			end
			STEP_INC: begin
				w = '{a_sel: A_ERR, b_sel: B_TIME, op: OP_DERIV, seq: SQ_NEXT,
					target: STEP_IDLE};
			end
			STEP_KP: begin
				w = '{a_sel: A_ERR, b_sel: B_KP, op: OP_INTEG, seq: SQ_NEXT,
					target: STEP_IDLE};
			end
			STEP_KD: begin
				w = '{a_sel: A_DERIV, b_sel: B_KD, op: OP_ACC_LOAD, seq: SQ_NEXT,
					target: STEP_IDLE};
			end
			STEP_KI_HI: begin
				w = '{a_sel: A_INT_HI, b_sel: B_KI, op: OP_ACC_ADD, seq: SQ_NEXT,
					target: STEP_IDLE};
			end
			STEP_KI_LO: begin
				w = '{a_sel: A_INT_LO, b_sel: B_KI, op: OP_HOLD_HI, seq: SQ_NEXT,
					target: STEP_IDLE};
			end
			STEP_TERM: begin
				w = '{a_sel: A_NONE, b_sel: B_NONE, op: OP_TERM, seq: SQ_NEXT,
					target: STEP_IDLE};
			end
			STEP_FINISH: begin
				w = '{a_sel: A_NONE, b_sel: B_NONE, op: OP_FINISH, seq: SQ_WAIT_OUT,
					target: STEP_IDLE};
			end
			STEP_ZERO: begin
				w = '{a_sel: A_NONE, b_sel: B_NONE, op: OP_ZERO, seq: SQ_WAIT_OUT,
					target: STEP_IDLE};
			end
			default: begin
				w = '{a_sel: A_NONE, b_sel: B_NONE, op: OP_NONE, seq: SQ_NEXT,
					target: STEP_IDLE};
			end
		endcase
		return w;
	endfunction

	// saturate a wide value to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [62:0] x);
		logic signed [31:0] r;
		r = x[31:0];
		if (!x[62] && (|x[61:31]))
			r = 32'sh7fffffff;
		else if (x[62] && !(&x[61:31]))
			r = 32'sh80000000;
		return r;
	endfunction

	// true when sat32 clips
	function automatic logic clip32(input logic signed [62:0] x);
		return (x[62] ? !(&x[61:31]) : (|x[61:31]));
	endfunction

endpackage

FILE: rtl/dual_axis_gimbal_pid.sv
// ----------------------------------------------------------------------------
// dual_axis_gimbal_pid
// Microcoded PID step for a pitch-rate loop and two gravity-turn loops.
// ----------------------------------------------------------------------------
// Each request runs one PID step and returns one result. The block takes a
// request only while its sequencer sits at the idle step; a request then runs
// an eight-step program over a single shared 33x33 signed multiplier (one
// product per step, registered); its final step loads the result into the
// output register once that register is empty or its result is being taken,
// and a new request can be taken in the cycle after the result is loaded,
// even while that result waits to be taken. A request with the unused action
// code branches to a zero step that loads a zero result the same way.
// Configuration writes go straight to the registers and must only be issued
// while no request is in flight.
module dual_axis_gimbal_pid import dagp_pkg::*; #(
	parameter int INTEGRAL_WIDTH = 48
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	// request channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic signed [31:0] measured,
	input  logic signed [31:0] commanded,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] gimbal_command,
	output logic               saturated
);

	localparam int SUM_W = ((INTEGRAL_WIDTH > 50) ? INTEGRAL_WIDTH : 50) + 1;
	localparam logic signed [SUM_W-1:0] INT_MAX =
		{{(SUM_W-INTEGRAL_WIDTH+1){1'b0}}, {(INTEGRAL_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] INT_MIN = ~INT_MAX;
	localparam logic signed [65:0] PART_LIM = 66'sd1 <<< 52;
	localparam logic signed [62:0] TERM_LIM = 63'sd1 <<< 60;

	// configuration registers
	logic signed [31:0] rate_kp_q, rate_ki_q, rate_kd_q;
	logic signed [31:0] turn_kp_q, turn_ki_q, turn_kd_q;
	logic [30:0]        time_q, inv_time_q;

	// loop state
	logic signed [31:0]               pitch_prev_q, yaw_prev_q;
	logic signed [INTEGRAL_WIDTH-1:0] pitch_int_q, yaw_int_q;

	// sequencer and datapath registers
	step_t              step_q, step_d;
	ctl_word_t          ctl;
	logic               rate_q, yaw_q, sat_q;
	logic signed [31:0] err_q, deriv_q;
	logic signed [65:0] prod_q;
	logic signed [41:0] acc_q;
	logic signed [53:0] hi_q;
	logic               hi_pos_q, hi_neg_q;
	logic signed [61:0] term_q;
	logic               out_valid_q, saturated_q;
	logic signed [31:0] gimbal_q;

	// combinational helpers
	logic                             in_accept, out_free, step_done;
	logic signed [31:0]               prev_sel, kp_sel, ki_sel, kd_sel;
	logic signed [INTEGRAL_WIDTH-1:0] int_sel;
	logic signed [63:0]               int_ext;
	logic signed [32:0]               mul_a, mul_b;
	logic signed [32:0]               err_diff;
	logic signed [49:0]               sh16;
	logic signed [41:0]               sh24;
	logic signed [SUM_W-1:0]          int_sum;
	logic signed [62:0]               term_raw, total;

	assign ctl       = ucode_rom(step_q);
	assign in_stall  = (ctl.seq != SQ_WAIT_IN);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign step_done = (ctl.seq == SQ_WAIT_OUT) && out_free;

	// per-axis and per-loop selection
	assign prev_sel = yaw_q ? yaw_prev_q : pitch_prev_q;
	assign int_sel  = yaw_q ? yaw_int_q : pitch_int_q;
	assign int_ext  = 64'(int_sel);
	assign kp_sel   = rate_q ? rate_kp_q : turn_kp_q;
	assign ki_sel   = rate_q ? rate_ki_q : turn_ki_q;
	assign kd_sel   = rate_q ? rate_kd_q : turn_kd_q;

	// error of the incoming request
	assign err_diff = ((action == ACT_RATE) ? 33'(commanded) : 33'sd0) - 33'(measured);

	// multiplier operand selection
	always_comb begin
		case (ctl.a_sel)
			A_DIFF:   mul_a = 33'(err_q) - 33'(prev_sel);
			A_ERR:    mul_a = 33'(err_q);
			A_DERIV:  mul_a = 33'(deriv_q);
			A_INT_HI: mul_a = $signed({int_ext[63], int_ext[63:32]});
			A_INT_LO: mul_a = $signed({1'b0, int_ext[31:0]});
			default:  mul_a = '0;
		endcase
		case (ctl.b_sel)
			B_INV_TIME: mul_b = $signed({2'b00, inv_time_q});
			B_TIME:     mul_b = $signed({2'b00, time_q});
			B_KP:       mul_b = 33'(kp_sel);
			B_KD:       mul_b = 33'(kd_sel);
			B_KI:       mul_b = 33'(ki_sel);
			default:    mul_b = '0;
		endcase
	end

	// product views and wide sums
	assign sh16     = $signed(prod_q[65:16]);
	assign sh24     = $signed(prod_q[65:24]);
	assign int_sum  = SUM_W'(int_sel) + SUM_W'(sh16);
	assign term_raw = (63'(hi_q) <<< 8) + 63'(sh24);
	assign total    = 63'(term_q) + 63'(acc_q);

	// next step
	always_comb begin
		step_d = step_q;
		unique case (ctl.seq)
			SQ_NEXT: begin
				step_d = step_q + 4'd1;
			end
			SQ_WAIT_IN: begin
				if (in_accept)
					step_d = (action == ACT_NULL) ? ctl.target : step_q + 4'd1;
			end
			SQ_WAIT_OUT: begin
				if (out_free)
					step_d = ctl.target;
			end
			default: begin
				step_d = STEP_IDLE;
			end
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= STEP_IDLE;
		else
			step_q <= step_d;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_kp_q  <= RST_RATE_KP;
			rate_ki_q  <= RST_RATE_KI;
			rate_kd_q  <= RST_RATE_KD;
			turn_kp_q  <= RST_TURN_KP;
			turn_ki_q  <= RST_TURN_KI;
			turn_kd_q  <= RST_TURN_KD;
			time_q     <= RST_TIME;
			inv_time_q <= RST_INV_TIME;
		end else if (cfg_write) begin
			unique case (reg_index_t'(cfg_index))
				REG_RATE_KP:  rate_kp_q  <= cfg_data;
				REG_RATE_KI:  rate_ki_q  <= cfg_data;
				REG_RATE_KD:  rate_kd_q  <= cfg_data;
				REG_TURN_KP:  turn_kp_q  <= cfg_data;
				REG_TURN_KI:  turn_ki_q  <= cfg_data;
				REG_TURN_KD:  turn_kd_q  <= cfg_data;
				REG_TIME:     time_q     <= cfg_data[30:0];
				REG_INV_TIME: inv_time_q <= cfg_data[30:0];
				default:      ;
			endcase
		end
	end

	// loop state and per-request flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_prev_q <= '0;
			yaw_prev_q   <= '0;
			pitch_int_q  <= '0;
			yaw_int_q    <= '0;
			rate_q       <= 1'b0;
			yaw_q        <= 1'b0;
			sat_q        <= 1'b0;
		end else begin
			if (in_accept) begin
				rate_q <= (action == ACT_RATE);
				yaw_q  <= (action == ACT_YAW_TURN);
				sat_q  <= 1'b0;
			end
			if (ctl.op == OP_DERIV) begin
				if (yaw_q)
					yaw_prev_q <= err_q;
				else
					pitch_prev_q <= err_q;
			end
			if (ctl.op == OP_INTEG) begin
				if (int_sum > INT_MAX || int_sum < INT_MIN)
					sat_q <= 1'b1;
				if (yaw_q) begin
					if (int_sum > INT_MAX)
						yaw_int_q <= INTEGRAL_WIDTH'(INT_MAX);
					else if (int_sum < INT_MIN)
						yaw_int_q <= INTEGRAL_WIDTH'(INT_MIN);
					else
						yaw_int_q <= INTEGRAL_WIDTH'(int_sum);
				end else begin
					if (int_sum > INT_MAX)
						pitch_int_q <= INTEGRAL_WIDTH'(INT_MAX);
					else if (int_sum < INT_MIN)
						pitch_int_q <= INTEGRAL_WIDTH'(INT_MIN);
					else
						pitch_int_q <= INTEGRAL_WIDTH'(int_sum);
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (in_accept)
			err_q <= sat32(63'(err_diff));
		case (ctl.op)
			OP_DERIV:    deriv_q <= sat32(63'(sh16));
			OP_ACC_LOAD: acc_q <= sh24;
			OP_ACC_ADD:  acc_q <= acc_q + sh24;
			OP_HOLD_HI: begin
				hi_q     <= prod_q[53:0];
				hi_pos_q <= (prod_q > PART_LIM);
				hi_neg_q <= (prod_q < -PART_LIM);
			end
			OP_TERM: begin
				if (hi_pos_q || term_raw > TERM_LIM)
					term_q <= 62'(TERM_LIM);
				else if (hi_neg_q || term_raw < -TERM_LIM)
					term_q <= 62'(-TERM_LIM);
				else
					term_q <= 62'(term_raw);
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (step_done)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step_done) begin
			if (ctl.op == OP_FINISH) begin
				gimbal_q    <= sat32(total);
				saturated_q <= sat_q || clip32(total);
			end else begin
				gimbal_q    <= '0;
				saturated_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign gimbal_command = gimbal_q;
	assign saturated      = saturated_q;

	// checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> in_stall)
		else $error("request taken while previous one still running");

	a_null_to_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && action == ACT_NULL) |=> step_q == STEP_ZERO)
		else $error("null action did not branch to the zero step");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_ZERO)
		else $error("step counter left the program");

	a_load_from_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(ctl.op == OP_FINISH || ctl.op == OP_ZERO))
		else $error("result loaded outside a final step");

endmodule

FILE: sim/tb_dual_axis_gimbal_pid.sv
// ----------------------------------------------------------------------------
// tb_dual_axis_gimbal_pid
// Self-checking bench for the dual-axis gimbal PID step.
// ----------------------------------------------------------------------------
// Every request taken by the block is run through a local fixed-point model of
// the three PID loops, with its own copy of the gains, the time registers and
// the pitch and yaw error history. The expected commands wait in order and each
// result taken from the block is compared field by field with the oldest one.
// Directed requests cover the field extremes, error overflow, the null action,
// zero time registers and integral clipping. Random phases then run under
// several register settings, with sender bursts and receiver stalls, one long
// receiver hold-off that backs the block up, and a stretch of lone requests.
// ----------------------------------------------------------------------------
module tb_dual_axis_gimbal_pid import dagp_pkg::*; ();

	localparam int     INTEGRAL_BITS  = 48;
	localparam int     WATCHDOG_LIMIT = 3000;
	localparam int     HOLD_CYCLES    = 400;
	localparam int     PRINT_LIMIT    = 40;
	localparam longint S32_MAX        = 64'sh0000_0000_7fff_ffff;
	localparam longint S32_MIN        = -S32_MAX - 1;
	localparam longint INTEG_MAX      = (64'sd1 <<< (INTEGRAL_BITS - 1)) - 1;
	localparam longint INTEG_MIN      = -INTEG_MAX - 1;
	localparam longint TERM_MAX       = 64'sd1 <<< 60;

	typedef struct packed {
		logic signed [31:0] command;
		logic               clipped;
	} gimbal_result_t;

	typedef enum {SET_DEFAULT, SET_RANDOM, SET_ALL_MAX, SET_ALL_MIN, SET_MODEST} settings_kind_t;
	typedef enum {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_t;

	// block ports
	logic               clk            = 1'b0;
	logic               arst_n         = 1'b0;
	logic               cfg_write      = 1'b0;
	logic [2:0]         cfg_index      = REG_RATE_KP;
	logic [31:0]        cfg_data       = '0;
	logic               in_valid       = 1'b0;
	logic               in_stall;
	logic [1:0]         action         = ACT_RATE;
	logic signed [31:0] measured       = '0;
	logic signed [31:0] commanded      = '0;
	logic               out_valid;
	logic               out_stall      = 1'b0;
	logic signed [31:0] gimbal_command;
	logic               saturated;

	// model of the gains, time registers and loop history
	longint             cfg_shadow [8];
	longint             pitch_prev_err = 0;
	longint             pitch_integral = 0;
	longint             yaw_prev_err   = 0;
	longint             yaw_integral   = 0;

	gimbal_result_t     pending_commands [$];
	logic [31:0]        next_settings [8];
	logic signed [31:0] track_value [3];
	int                 mismatch_count = 0;
	int                 burst_left     = 0;
	bit                 sender_idles   = 1'b1;
	stall_mode_t        stall_mode     = STALL_RANDOM;
	int                 hold_requests  = 0;
	int                 hold_served    = 0;
	int                 hold_left      = 0;
	int                 recv_cycle     = 0;
	int                 quiet_cycles   = 0;

	dual_axis_gimbal_pid #(
		.INTEGRAL_WIDTH(INTEGRAL_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.measured(measured),
		.commanded(commanded),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.gimbal_command(gimbal_command),
		.saturated(saturated)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------------
	// fixed-point model
	// ------------------------------------------------------------------------

	function automatic longint clamp_s32(input longint x);
		if (x > S32_MAX)
			return S32_MAX;
		if (x < S32_MIN)
			return S32_MIN;
		return x;
	endfunction

	// one PID step: updates the loop history and returns the expected result
	function automatic gimbal_result_t compute_gimbal_command(input action_t act,
			input logic signed [31:0] meas, input logic signed [31:0] cmd);
		gimbal_result_t     r;
		longint             kp, ki, kd, err, prev, integ, deriv, inc, ki_term, sum;
		logic signed [95:0] ki_prod;
		r.command = '0;
		r.clipped = 1'b0;
		if (act == ACT_NULL)
			return r;
		prev  = (act == ACT_YAW_TURN) ? yaw_prev_err : pitch_prev_err;
		integ = (act == ACT_YAW_TURN) ? yaw_integral : pitch_integral;
		if (act == ACT_RATE) begin
			kp  = cfg_shadow[REG_RATE_KP];
			ki  = cfg_shadow[REG_RATE_KI];
			kd  = cfg_shadow[REG_RATE_KD];
			err = longint'(cmd) - longint'(meas);
		end else begin
			kp  = cfg_shadow[REG_TURN_KP];
			ki  = cfg_shadow[REG_TURN_KI];
			kd  = cfg_shadow[REG_TURN_KD];
			err = -longint'(meas);
		end
		// error and derivative clip silently
		err   = clamp_s32(err);
		deriv = clamp_s32(((err - prev) * cfg_shadow[REG_INV_TIME]) >>> 16);
		prev  = err;
		// integral accumulates with clipping at the accumulator width
		inc = (err * cfg_shadow[REG_TIME]) >>> 16;
		if (inc > 0 && integ > INTEG_MAX - inc) begin
			integ     = INTEG_MAX;
			r.clipped = 1'b1;
		end else if (inc < 0 && integ < INTEG_MIN - inc) begin
			integ     = INTEG_MIN;
			r.clipped = 1'b1;
		end else begin
			integ = integ + inc;
		end
		if (act == ACT_YAW_TURN) begin
			yaw_prev_err = prev;
			yaw_integral = integ;
		end else begin
			pitch_prev_err = prev;
			pitch_integral = integ;
		end
		// integral term can exceed 64 bits before the shift
		ki_prod = (96'(ki) * 96'(integ)) >>> 24;
		if (ki_prod > 96'(TERM_MAX))
			ki_term = TERM_MAX;
		else if (ki_prod < -96'(TERM_MAX))
			ki_term = -TERM_MAX;
		else
			ki_term = longint'(ki_prod);
		sum = ((kp * err) >>> 24) + ki_term + ((kd * deriv) >>> 24);
		if (clamp_s32(sum) != sum)
			r.clipped = 1'b1;
		r.command = clamp_s32(sum);
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	function automatic logic signed [31:0] pick_sample();
		case ($urandom_range(0, 7))
			0, 1, 2: return $urandom;
			3, 4:    return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
			5:       return 32'sh7fff_ffff - $urandom_range(0, 3);
			6:       return 32'sh8000_0000 + $urandom_range(0, 3);
			default: return $signed($urandom_range(0, 2)) - 1;
		endcase
	endfunction

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(0, 7))
			0, 1:    return $urandom;
			2, 3:    return $signed($urandom_range(0, 1 << 26)) - (1 << 25);
			4:       return 32'h7fff_ffff;
			5:       return 32'h8000_0000;
			6:       return '0;
			default: return $urandom_range(0, 1 << 20);
		endcase
	endfunction

	// bit 31 of the time registers is left random, the block must drop it
	function automatic logic [31:0] pick_time();
		case ($urandom_range(0, 6))
			0, 1:    return $urandom;
			2:       return {1'($urandom_range(0, 1)), 31'd0};
			3:       return {1'($urandom_range(0, 1)), 31'h7fff_ffff};
			4:       return 32'd1;
			default: return $urandom_range(1, 1 << 18);
		endcase
	endfunction

	function automatic void choose_settings(input settings_kind_t kind);
		case (kind)
			SET_DEFAULT: begin
				next_settings[REG_RATE_KP]  = RST_RATE_KP;
				next_settings[REG_RATE_KI]  = RST_RATE_KI;
				next_settings[REG_RATE_KD]  = RST_RATE_KD;
				next_settings[REG_TURN_KP]  = RST_TURN_KP;
				next_settings[REG_TURN_KI]  = RST_TURN_KI;
				next_settings[REG_TURN_KD]  = RST_TURN_KD;
				next_settings[REG_TIME]     = {1'b0, RST_TIME};
				next_settings[REG_INV_TIME] = {1'b0, RST_INV_TIME};
			end
			SET_ALL_MAX: begin
				for (int i = REG_RATE_KP; i <= REG_TURN_KD; i++)
					next_settings[i] = 32'h7fff_ffff;
				next_settings[REG_TIME]     = 32'hffff_ffff;
				next_settings[REG_INV_TIME] = 32'hffff_ffff;
			end
			SET_ALL_MIN: begin
				for (int i = REG_RATE_KP; i <= REG_TURN_KD; i++)
					next_settings[i] = 32'h8000_0000;
				next_settings[REG_TIME]     = 32'd1;
				next_settings[REG_INV_TIME] = 32'd1;
			end
			SET_MODEST: begin
				for (int i = REG_RATE_KP; i <= REG_TURN_KD; i++)
					next_settings[i] = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
				next_settings[REG_TIME]     = $urandom_range(1, 1 << 12);
				next_settings[REG_INV_TIME] = $urandom_range(1, 1 << 24);
			end
			default: begin
				for (int i = REG_RATE_KP; i <= REG_TURN_KD; i++)
					next_settings[i] = pick_gain();
				next_settings[REG_TIME]     = pick_time();
				next_settings[REG_INV_TIME] = pick_time();
			end
		endcase
	endfunction

	// writes all registers from next_settings, block must be idle
	task automatic apply_settings();
		for (int i = REG_RATE_KP; i <= REG_INV_TIME; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= reg_index_t'(i);
			cfg_data  <= next_settings[i];
			@(posedge clk);
			if (i <= REG_TURN_KD)
				cfg_shadow[i] = longint'($signed(next_settings[i]));
			else
				cfg_shadow[i] = longint'(next_settings[i][30:0]);
		end
		cfg_write <= 1'b0;
	endtask

	// offer one request, idling first if sender idling is on and the current burst is used up
	task automatic send_request(input action_t act, input logic signed [31:0] meas,
			input logic signed [31:0] cmd);
		int gap;
		if (sender_idles) begin
			if (burst_left == 0) begin
				gap        = $urandom_range(1, 8);
				burst_left = $urandom_range(1, 24);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left--;
		end
		in_valid  <= 1'b1;
		action    <= act;
		measured  <= meas;
		commanded <= cmd;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_commands.push_back(compute_gimbal_command(act, meas, cmd));
	endtask

	// mostly slowly drifting loop inputs, the rest arbitrary
	task automatic send_random_request();
		action_t            act;
		logic signed [31:0] meas, cmd;
		int                 sel;
		sel = $urandom_range(0, 15);
		if (sel < 5)
			act = ACT_RATE;
		else if (sel < 10)
			act = ACT_PITCH_TURN;
		else if (sel < 15)
			act = ACT_YAW_TURN;
		else
			act = ACT_NULL;
		if (act == ACT_NULL) begin
			meas = $urandom;
			cmd  = $urandom;
		end else if ($urandom_range(0, 9) < 6) begin
			meas = track_value[act] + ($signed($urandom_range(0, 8192)) - 4096);
			cmd  = meas + ($signed($urandom_range(0, 1 << 18)) - (1 << 17));
			track_value[act] = meas;
		end else begin
			meas = pick_sample();
			cmd  = pick_sample();
			track_value[act] = meas;
		end
		send_request(act, meas, cmd);
	endtask

	// drop valid and wait until every expected result has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_commands.size() != 0);
	endtask

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("ERROR: %s", what);
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// reset settings, field extremes, error overflow, null action
	task automatic test_field_extremes();
		send_request(ACT_RATE, 32'sd0, 32'sd0);
		send_request(ACT_RATE, 32'sh8000_0000, 32'sh7fff_ffff);
		send_request(ACT_RATE, 32'sh7fff_ffff, 32'sh8000_0000);
		send_request(ACT_RATE, 32'sd1, -32'sd1);
		send_request(ACT_PITCH_TURN, 32'sh8000_0000, 32'sd0);
		send_request(ACT_PITCH_TURN, 32'sh7fff_ffff, 32'sd0);
		send_request(ACT_YAW_TURN, 32'sh8000_0000, 32'sh7fff_ffff);
		send_request(ACT_YAW_TURN, 32'sh7fff_ffff, 32'sh8000_0000);
		send_request(ACT_NULL, $urandom, $urandom);
		send_request(ACT_NULL, 32'shffff_ffff, 32'shffff_ffff);
		wait_drained();
	endtask

	// zero time step freezes the integral, zero inverse kills the derivative
	task automatic test_zero_time_registers();
		choose_settings(SET_DEFAULT);
		next_settings[REG_TIME]     = '0;
		next_settings[REG_INV_TIME] = '0;
		apply_settings();
		send_request(ACT_RATE, 32'sh0003_0000, 32'sh0001_0000);
		send_request(ACT_PITCH_TURN, 32'sh0002_8000, 32'sd0);
		send_request(ACT_YAW_TURN, -32'sh0004_0000, 32'sd0);
		send_request(ACT_RATE, 32'sh8000_0000, 32'sh7fff_ffff);
		wait_drained();
	endtask

	// drive both integrals into their upper limits, then push the pitch one back down
	task automatic test_integral_limits();
		choose_settings(SET_DEFAULT);
		next_settings[REG_RATE_KI]  = 32'h7fff_ffff;
		next_settings[REG_TURN_KI]  = 32'h8000_0000;
		next_settings[REG_TIME]     = 32'h7fff_ffff;
		repeat (3)
			send_request(ACT_RATE, 32'sh8000_0000, 32'sh7fff_ffff);
		wait_drained();
		apply_settings();
		repeat (3)
			send_request(ACT_RATE, 32'sh8000_0000, 32'sh7fff_ffff);
		repeat (3)
			send_request(ACT_RATE, 32'sh7fff_ffff, 32'sh8000_0000);
		repeat (3)
			send_request(ACT_YAW_TURN, 32'sh8000_0000, 32'sd0);
		wait_drained();
	endtask

	// random traffic under a series of register settings
	task automatic test_random_phases();
		settings_kind_t kind;
		for (int p = 0; p < 6; p++) begin
			kind = (p == 5) ? SET_RANDOM : settings_kind_t'(p);
			choose_settings(kind);
			apply_settings();
			sender_idles = (p != 2);
			if (p == 2)
				stall_mode = STALL_NONE;
			else
				stall_mode = p[0] ? STALL_PATTERN : STALL_RANDOM;
			repeat (150)
				send_random_request();
			wait_drained();
		end
	endtask

	// receiver holds off for a long stretch while requests keep coming
	task automatic test_receiver_hold_off();
		choose_settings(SET_DEFAULT);
		apply_settings();
		sender_idles = 1'b0;
		stall_mode   = STALL_RANDOM;
		hold_requests++;
		repeat (60)
			send_random_request();
		wait_drained();
	endtask

	// each request alone in the block
	task automatic test_isolated_steps();
		choose_settings(SET_RANDOM);
		apply_settings();
		stall_mode = STALL_PATTERN;
		repeat (40) begin
			send_random_request();
			wait_drained();
		end
	endtask

	// ------------------------------------------------------------------------
	// receiver stall pattern and long hold-off
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		recv_cycle <= recv_cycle + 1;
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_requests) begin
			out_stall   <= 1'b1;
			hold_served <= hold_requests;
			hold_left   <= HOLD_CYCLES;
		end else begin
			case (stall_mode)
				STALL_RANDOM:  out_stall <= ($urandom_range(0, 99) < 35);
				STALL_PATTERN: out_stall <= ((recv_cycle % 13) < 5);
				default:       out_stall <= 1'b0;
			endcase
		end
	end

	// result check against the oldest expectation
	always @(posedge clk) begin : check_results
		gimbal_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_commands.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				want = pending_commands.pop_front();
				if (gimbal_command !== want.command)
					report_mismatch($sformatf("gimbal_command got %0d expected %0d",
						gimbal_command, $signed(want.command)));
				if (saturated !== want.clipped)
					report_mismatch($sformatf("saturated got %b expected %b",
						saturated, want.clipped));
			end
		end
	end

	// watchdog on cycles with no transfer at all
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("ERROR: no transfer for %0d cycles", quiet_cycles);
				$display("dual_axis_gimbal_pid: mismatch");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------------
	initial begin
		cfg_shadow[REG_RATE_KP]  = RST_RATE_KP;
		cfg_shadow[REG_RATE_KI]  = RST_RATE_KI;
		cfg_shadow[REG_RATE_KD]  = RST_RATE_KD;
		cfg_shadow[REG_TURN_KP]  = RST_TURN_KP;
		cfg_shadow[REG_TURN_KI]  = RST_TURN_KI;
		cfg_shadow[REG_TURN_KD]  = RST_TURN_KD;
		cfg_shadow[REG_TIME]     = RST_TIME;
		cfg_shadow[REG_INV_TIME] = RST_INV_TIME;
		track_value[ACT_RATE]       = '0;
		track_value[ACT_PITCH_TURN] = '0;
		track_value[ACT_YAW_TURN]   = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_field_extremes();
		test_zero_time_registers();
		test_integral_limits();
		test_random_phases();
		test_receiver_hold_off();
		test_isolated_steps();
		repeat (20) @(posedge clk);
		if (pending_commands.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_commands.size()));
		if (mismatch_count == 0)
			$display("dual_axis_gimbal_pid: match");
		else
			$display("dual_axis_gimbal_pid: mismatch");
		$finish;
	end

endmodule
